// ===== sv/sfc_aq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_aq_pkg
// Shared types and codes for the sequential-function-chart action qualifier.
// ----------------------------------------------------------------------------
package sfc_aq_pkg;

  localparam int unsigned NowW  = 63;
  localparam int unsigned TimeW = 32;
  localparam int unsigned ModeW = 4;
  localparam int unsigned CfgW  = 32;

  // qualifier codes, anything above SL is invalid
  typedef enum logic [ModeW-1:0] {
    Q_N  = 4'd0,
    Q_S  = 4'd1,
    Q_R  = 4'd2,
    Q_P  = 4'd3,
    Q_L  = 4'd4,
    Q_D  = 4'd5,
    Q_SD = 4'd6,
    Q_DS = 4'd7,
    Q_SL = 4'd8
  } qual_e;

  // word operation
  typedef enum logic {
    OP_EXEC  = 1'b0,
    OP_RESET = 1'b1
  } op_e;

  // configuration register indexes
  typedef enum logic {
    CFG_MODE = 1'b0,
    CFG_TIME = 1'b1
  } cfg_idx_e;

  // action state: a start time of minus one is held as started = 0
  typedef struct packed {
    logic            on;
    logic            started;
    logic [NowW-1:0] start;
  } act_state_t;

endpackage

// ===== sv/sfc_aq_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_aq_core
// Next-state logic of one action: qualifier decode and elapsed-time check.
// ----------------------------------------------------------------------------
module sfc_aq_core
  import sfc_aq_pkg::*;
(
  input  act_state_t             cur_i,
  input  logic [ModeW-1:0]       mode_i,
  input  logic [TimeW-1:0]       time_value_i,
  input  logic                   op_i,
  input  logic                   step_active_i,
  input  logic                   step_activated_i,
  input  logic                   step_deactivated_i,
  input  logic [NowW-1:0]        now_time_i,
  output act_state_t             nxt_o,
  output logic                   bad_mode_o
);

  logic [NowW+1:0] sub_op;
  logic [NowW+1:0] diff;
  logic            elapsed;
  logic            pos_start;

  // exact signed difference now - start, no start counts as minus one
  assign sub_op    = cur_i.started ? {2'b00, cur_i.start} : '1;
  assign diff      = {2'b00, now_time_i} - sub_op;
  assign elapsed   = !diff[NowW+1] &&
                     (diff[NowW:0] >= {{(NowW+1-TimeW){1'b0}}, time_value_i});
  assign pos_start = cur_i.started && (cur_i.start != '0);

  // qualifier behaviour
  always_comb begin
    nxt_o      = cur_i;
    bad_mode_o = 1'b0;
    if (op_e'(op_i) == OP_RESET) begin
      nxt_o.on      = 1'b0;
      nxt_o.started = 1'b0;
    end else begin
      case (qual_e'(mode_i))
        Q_N: nxt_o.on = step_active_i;
        Q_S: begin
          if (step_activated_i) nxt_o.on = 1'b1;
        end
        Q_R: begin
          if (step_activated_i) nxt_o.on = 1'b0;
        end
        Q_P: nxt_o.on = step_activated_i || step_deactivated_i;
        Q_L: begin
          if (step_activated_i) begin
            nxt_o.on      = 1'b1;
            nxt_o.started = 1'b1;
            nxt_o.start   = now_time_i;
          end else if (step_active_i) begin
            if (elapsed) nxt_o.on = 1'b0;
          end else begin
            nxt_o.on = 1'b0;
          end
        end
        Q_D: begin
          if (step_activated_i) begin
            nxt_o.on      = 1'b0;
            nxt_o.started = 1'b1;
            nxt_o.start   = now_time_i;
          end else if (step_active_i) begin
            if (elapsed) nxt_o.on = 1'b1;
          end else begin
            nxt_o.on = 1'b0;
          end
        end
        Q_SD: begin
          if (step_activated_i) begin
            nxt_o.on      = 1'b0;
            nxt_o.started = 1'b1;
            nxt_o.start   = now_time_i;
          end else if (pos_start && elapsed) begin
            nxt_o.on = 1'b1;
          end
        end
        Q_DS: begin
          if (step_activated_i) begin
            nxt_o.on      = 1'b0;
            nxt_o.started = 1'b1;
            nxt_o.start   = now_time_i;
          end else if (step_active_i && pos_start && elapsed) begin
            nxt_o.on = 1'b1;
          end
        end
        Q_SL: begin
          if (step_activated_i) begin
            nxt_o.on      = 1'b1;
            nxt_o.started = 1'b1;
            nxt_o.start   = now_time_i;
          end else if (cur_i.on && pos_start && elapsed) begin
            nxt_o.on = 1'b0;
          end
        end
        default: bad_mode_o = 1'b1;
      endcase
    end
  end

endmodule

// ===== sv/sfc_action_qualifier_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_action_qualifier_top
// One chart action driven by a configured IEC 61131-3 style qualifier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one word per call: an
//   execute or reset operation, the three step flags and the current time.
//   Output channel (out_valid_o / out_ready_i) returns one word per input
//   word: the action flag after that word and a bad qualifier flag.
//   Configuration (cfg_we_i, cfg_addr_i, cfg_wdata_i) sets the qualifier
//   and the time value; write it only while no word is in flight.
// Timing:
//   out_valid_o rises the cycle after acceptance; one word per cycle is
//   sustained while out_ready_i is high, set by the single output register
//   that holds the result while the action state updates at acceptance.
// Reset:
//   clears the action state (flag off, no start time), the configuration
//   and the output valid flag.
// Stall:
//   while out_valid_o is high and out_ready_i low the result holds and
//   in_ready_o is low; a word taken in the same cycle lets a new one in.
// ----------------------------------------------------------------------------
module sfc_action_qualifier_top
  import sfc_aq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_addr_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  input  logic             step_active_i,
  input  logic             step_activated_i,
  input  logic             step_deactivated_i,
  input  logic [NowW-1:0]  now_time_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             action_on_o,
  output logic             bad_mode_o
);

  logic [ModeW-1:0] mode_q;
  logic [TimeW-1:0] time_value_q;
  act_state_t       st_q;
  act_state_t       st_d;
  logic             bad_d;
  logic             out_valid_q;
  logic             action_on_q;
  logic             bad_mode_q;
  logic             in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= '0;
      time_value_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_MODE: mode_q       <= cfg_wdata_i[ModeW-1:0];
        CFG_TIME: time_value_q <= cfg_wdata_i[TimeW-1:0];
        default:  ;
      endcase
    end
  end

  // qualifier next state
  sfc_aq_core u_core (
    .cur_i              (st_q),
    .mode_i             (mode_q),
    .time_value_i       (time_value_q),
    .op_i               (op_i),
    .step_active_i      (step_active_i),
    .step_activated_i   (step_activated_i),
    .step_deactivated_i (step_deactivated_i),
    .now_time_i         (now_time_i),
    .nxt_o              (st_d),
    .bad_mode_o         (bad_d)
  );

  // action state, updated on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (in_fire) begin
      st_q <= st_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      action_on_q <= st_d.on;
      bad_mode_q  <= bad_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign action_on_o = action_on_q;
  assign bad_mode_o  = bad_mode_q;

endmodule

// ===== sv/sfc_aq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_aq_checker
// Port-level checks on the action qualifier, bound to the top level.
// ----------------------------------------------------------------------------
module sfc_aq_checker
  import sfc_aq_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic op_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic action_on_o,
  input logic bad_mode_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(action_on_o) && $stable(bad_mode_o))
    else $error("stalled result changed");

  // a full output register with a stalled receiver blocks the input
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted over a stalled result");

  // an empty output register always takes a word
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // a reset word gives an off, good-mode result next cycle
  a_reset_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == OP_RESET) |=>
      out_valid_o && !action_on_o && !bad_mode_o)
    else $error("reset word result wrong");

endmodule

bind sfc_action_qualifier_top sfc_aq_checker u_sfc_aq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .op_i        (op_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .action_on_o (action_on_o),
  .bad_mode_o  (bad_mode_o)
);

// ===== verif/tb_sfc_action_qualifier_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sfc_action_qualifier_top
// Self-checking bench for the chart action qualifier. A short table of words
// walks every qualifier, both operations, the invalid codes and the timing
// corner cases. Random phases with fresh qualifier and time settings follow,
// mostly as step activate / active / deactivate cycles with random time
// steps. Each result word is checked against an in-bench action predictor.
// ----------------------------------------------------------------------------
module tb_sfc_action_qualifier_top;
  import sfc_aq_pkg::*;

  localparam logic [NowW-1:0]  NOW_MAX     = '1;
  localparam logic [TimeW-1:0] TIME_MAX    = '1;
  localparam logic [ModeW-1:0] MODE_BAD_LO = 4'd9;
  localparam logic [ModeW-1:0] MODE_BAD_HI = 4'd15;
  localparam int unsigned      RandWords   = 1750;
  localparam int unsigned      QuietFrom   = 700;
  localparam int unsigned      QuietTo     = 900;
  localparam int unsigned      HoldAtWord  = 500;
  localparam int unsigned      HoldCycles  = 200;

  // one input word and one result word
  typedef struct packed {
    op_e             op;
    logic            act;
    logic            rise;
    logic            fall;
    logic [NowW-1:0] now;
  } word_t;

  typedef struct packed {
    logic on;
    logic bad;
  } verdict_t;

  // directed row: settings, word, and a typed-in result where obvious
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [TimeW-1:0] tval;
    word_t            w;
    logic             typed;
    verdict_t         want;
  } row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_addr_i;
  logic [CfgW-1:0]  cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             op_i;
  logic             step_active_i;
  logic             step_activated_i;
  logic             step_deactivated_i;
  logic [NowW-1:0]  now_time_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             action_on_o;
  logic             bad_mode_o;

  // predictor state and its copy of the registers
  logic                pr_on;
  logic signed [63:0]  pr_start;
  logic [ModeW-1:0]    pr_mode;
  logic [TimeW-1:0]    pr_tval;

  verdict_t    pending_actions[$];
  verdict_t    due;
  int unsigned mismatch_count;
  int unsigned words_out;
  bit          quiet;

  row_t plan [25] = '{
    // follow the step, flag extremes, reset ignores the flags
    '{Q_N, 32'd0, '{OP_EXEC, 1'b1, 1'b0, 1'b0, 63'd0}, 1'b1, '{1'b1, 1'b0}},
    '{Q_N, 32'd0, '{OP_EXEC, 1'b0, 1'b1, 1'b1, NOW_MAX}, 1'b1, '{1'b0, 1'b0}},
    '{Q_N, 32'd0, '{OP_RESET, 1'b1, 1'b1, 1'b1, NOW_MAX}, 1'b1, '{1'b0, 1'b0}},
    // set, hold, reset, pulse on either edge
    '{Q_S, 32'd0, '{OP_EXEC, 1'b0, 1'b1, 1'b0, 63'd5}, 1'b1, '{1'b1, 1'b0}},
    '{Q_S, 32'd0, '{OP_EXEC, 1'b0, 1'b0, 1'b0, 63'd6}, 1'b1, '{1'b1, 1'b0}},
    '{Q_R, 32'd0, '{OP_EXEC, 1'b1, 1'b1, 1'b0, 63'd7}, 1'b1, '{1'b0, 1'b0}},
    '{Q_P, 32'd0, '{OP_EXEC, 1'b0, 1'b0, 1'b1, 63'd8}, 1'b1, '{1'b1, 1'b0}},
    '{Q_P, 32'd0, '{OP_EXEC, 1'b1, 1'b0, 1'b0, 63'd9}, 1'b1, '{1'b0, 1'b0}},
    // limited: on at activation, off once the limit has run out
    '{Q_L, 32'd10, '{OP_EXEC, 1'b1, 1'b1, 1'b0, 63'd100}, 1'b1, '{1'b1, 1'b0}},
    '{Q_L, 32'd10, '{OP_EXEC, 1'b1, 1'b0, 1'b0, 63'd109}, 1'b0, '{1'b0, 1'b0}},
    '{Q_L, 32'd10, '{OP_EXEC, 1'b1, 1'b0, 1'b0, 63'd110}, 1'b0, '{1'b0, 1'b0}},
    // delayed from no start time: the span counts from minus one
    '{Q_D, 32'd10, '{OP_RESET, 1'b0, 1'b0, 1'b0, 63'd0}, 1'b1, '{1'b0, 1'b0}},
    '{Q_D, 32'd10, '{OP_EXEC, 1'b1, 1'b0, 1'b0, 63'd9}, 1'b0, '{1'b0, 1'b0}},
    '{Q_D, 32'd5, '{OP_EXEC, 1'b1, 1'b1, 1'b0, 63'd200}, 1'b0, '{1'b0, 1'b0}},
    '{Q_D, 32'd5, '{OP_EXEC, 1'b1, 1'b0, 1'b0, 63'd205}, 1'b0, '{1'b0, 1'b0}},
    // stored modes never time out from a start time of zero
    '{Q_SD, 32'd0, '{OP_EXEC, 1'b0, 1'b1, 1'b0, 63'd0}, 1'b1, '{1'b0, 1'b0}},
    '{Q_SD, 32'd0, '{OP_EXEC, 1'b0, 1'b0, 1'b0, 63'd1000}, 1'b0, '{1'b0, 1'b0}},
    '{Q_DS, 32'd3, '{OP_EXEC, 1'b1, 1'b1, 1'b0, 63'd50}, 1'b0, '{1'b0, 1'b0}},
    '{Q_DS, 32'd3, '{OP_EXEC, 1'b0, 1'b0, 1'b0, 63'd60}, 1'b0, '{1'b0, 1'b0}},
    '{Q_DS, 32'd3, '{OP_EXEC, 1'b1, 1'b0, 1'b0, 63'd60}, 1'b0, '{1'b0, 1'b0}},
    // largest limit, time going backwards gives a negative span
    '{Q_SL, TIME_MAX, '{OP_EXEC, 1'b1, 1'b1, 1'b0, NOW_MAX}, 1'b1, '{1'b1, 1'b0}},
    '{Q_SL, TIME_MAX, '{OP_EXEC, 1'b0, 1'b0, 1'b0, 63'd0}, 1'b0, '{1'b0, 1'b0}},
    // invalid codes keep the state
    '{MODE_BAD_LO, TIME_MAX, '{OP_EXEC, 1'b1, 1'b1, 1'b1, 63'd3}, 1'b0, '{1'b0, 1'b0}},
    '{MODE_BAD_HI, 32'd0, '{OP_EXEC, 1'b0, 1'b0, 1'b0, NOW_MAX}, 1'b0, '{1'b0, 1'b0}},
    '{Q_N, 32'd0, '{OP_RESET, 1'b0, 1'b0, 1'b0, 63'd0}, 1'b1, '{1'b0, 1'b0}}
  };

  sfc_action_qualifier_top u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_addr_i         (cfg_addr_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .op_i               (op_i),
    .step_active_i      (step_active_i),
    .step_activated_i   (step_activated_i),
    .step_deactivated_i (step_deactivated_i),
    .now_time_i         (now_time_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .action_on_o        (action_on_o),
    .bad_mode_o         (bad_mode_o)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // exact span since the start time, no wrap, negative never counts
  function automatic logic time_up(logic [NowW-1:0] now);
    logic signed [65:0] span;
    span = $signed({3'b000, now}) - $signed({{2{pr_start[63]}}, pr_start});
    return !span[65] && (span >= $signed({34'd0, pr_tval}));
  endfunction

  // action predictor: advance the state by one word, return the result word
  function automatic verdict_t qualify_word(word_t w);
    verdict_t v;
    v = '0;
    if (w.op == OP_RESET) begin
      pr_on    = 1'b0;
      pr_start = '1;
      return v;
    end
    case (pr_mode)
      Q_N: pr_on = w.act;
      Q_S: if (w.rise) pr_on = 1'b1;
      Q_R: if (w.rise) pr_on = 1'b0;
      Q_P: pr_on = w.rise | w.fall;
      Q_L: begin
        if (w.rise) begin
          pr_on    = 1'b1;
          pr_start = {1'b0, w.now};
        end else if (w.act) begin
          if (time_up(w.now)) pr_on = 1'b0;
        end else begin
          pr_on = 1'b0;
        end
      end
      Q_D: begin
        if (w.rise) begin
          pr_start = {1'b0, w.now};
          pr_on    = 1'b0;
        end else if (w.act) begin
          if (time_up(w.now)) pr_on = 1'b1;
        end else begin
          pr_on = 1'b0;
        end
      end
      Q_SD: begin
        if (w.rise) begin
          pr_start = {1'b0, w.now};
          pr_on    = 1'b0;
        end else if (pr_start > 0) begin
          if (time_up(w.now)) pr_on = 1'b1;
        end
      end
      Q_DS: begin
        if (w.rise) begin
          pr_start = {1'b0, w.now};
          pr_on    = 1'b0;
        end else if (w.act && pr_start > 0) begin
          if (time_up(w.now)) pr_on = 1'b1;
        end
      end
      Q_SL: begin
        if (w.rise) begin
          pr_on    = 1'b1;
          pr_start = {1'b0, w.now};
        end else if (pr_on && pr_start > 0) begin
          if (time_up(w.now)) pr_on = 1'b0;
        end
      end
      default: v.bad = 1'b1;
    endcase
    v.on = pr_on;
    return v;
  endfunction

  // let the block drain, then write both registers
  task automatic set_config(input logic [ModeW-1:0] mode, input logic [TimeW-1:0] tval);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_actions.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_MODE;
    cfg_wdata_i <= CfgW'(mode);
    @(negedge clk_i);
    cfg_addr_i  <= CFG_TIME;
    cfg_wdata_i <= CfgW'(tval);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    pr_mode = mode;
    pr_tval = tval;
  endtask

  // offer one word, with random idle cycles ahead of it
  task automatic send_word(input word_t w, input logic typed, input verdict_t want);
    verdict_t predicted;
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 28) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    op_i               <= w.op;
    step_active_i      <= w.act;
    step_activated_i   <= w.rise;
    step_deactivated_i <= w.fall;
    now_time_i         <= w.now;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    predicted = qualify_word(w);
    // queue the expected result behind the ones still due
    pending_actions = {pending_actions, (typed ? want : predicted)};
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_out++;
      if (pending_actions.size() == 0) begin
        $error("result word with nothing expected: action_on %0b bad_mode %0b",
               action_on_o, bad_mode_o);
        mismatch_count++;
      end else begin
        due = pending_actions.pop_front();
        if (action_on_o !== due.on) begin
          $error("action_on: expected %0b, got %0b", due.on, action_on_o);
          mismatch_count++;
        end
        if (bad_mode_o !== due.bad) begin
          $error("bad_mode: expected %0b, got %0b", due.bad, bad_mode_o);
          mismatch_count++;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    out_ready_i = 1'b0;
    hold_left   = 0;
    hold_done   = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (!hold_done && words_out >= HoldAtWord) begin
        hold_done   = 1'b1;
        hold_left   = HoldCycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= quiet || ($urandom_range(0, 99) >= 28);
      end
    end
  end

  // stimulus
  initial begin
    int unsigned      sent;
    int unsigned      roll;
    int unsigned      phase_len;
    word_t            w;
    logic [NowW-1:0]  clock_now;
    bit               step_up;
    logic [ModeW-1:0] mode;
    logic [TimeW-1:0] tval;

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_addr_i         = CFG_MODE;
    cfg_wdata_i        = '0;
    in_valid_i         = 1'b0;
    op_i               = OP_EXEC;
    step_active_i      = 1'b0;
    step_activated_i   = 1'b0;
    step_deactivated_i = 1'b0;
    now_time_i         = '0;
    quiet              = 1'b0;
    mismatch_count     = 0;
    words_out          = 0;
    pr_on              = 1'b0;
    pr_start           = '1;
    pr_mode            = Q_N;
    pr_tval            = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (plan[i]) begin
      if (plan[i].mode != pr_mode || plan[i].tval != pr_tval)
        set_config(plan[i].mode, plan[i].tval);
      send_word(plan[i].w, plan[i].typed, plan[i].want);
    end

    // random phases, each with its own qualifier and time value
    sent      = 0;
    clock_now = '0;
    step_up   = 1'b0;
    while (sent < RandWords) begin
      roll = $urandom_range(0, 99);
      mode = (roll < 12) ? ModeW'($urandom_range(9, 15)) : ModeW'($urandom_range(0, 8));
      roll = $urandom_range(0, 9);
      if (roll == 0)      tval = '0;
      else if (roll == 1) tval = TIME_MAX;
      else if (roll == 2) tval = TimeW'($urandom);
      else                tval = TimeW'($urandom_range(1, 40));
      set_config(mode, tval);
      phase_len = $urandom_range(20, 80);
      repeat (phase_len) begin
        quiet     = (sent >= QuietFrom && sent < QuietTo);
        w         = '0;
        w.op      = OP_EXEC;
        clock_now = clock_now + NowW'($urandom_range(0, pr_tval / 3 + 2));
        roll      = $urandom_range(0, 99);
        if (roll < 3) begin
          // reset word with junk flags
          w.op   = OP_RESET;
          w.act  = 1'($urandom);
          w.rise = 1'($urandom);
          w.fall = 1'($urandom);
        end else if (roll < 13) begin
          // noise: any flag mix, sometimes a jump anywhere in time
          w.act  = 1'($urandom);
          w.rise = 1'($urandom);
          w.fall = 1'($urandom);
          if ($urandom_range(0, 1) != 0) clock_now = NowW'({$urandom, $urandom});
        end else if (step_up) begin
          // step active, now and then it goes inactive
          if ($urandom_range(0, 99) < 15) begin
            w.fall  = 1'b1;
            step_up = 1'b0;
          end else begin
            w.act = 1'b1;
          end
        end else if ($urandom_range(0, 99) < 25) begin
          w.rise  = 1'b1;
          w.act   = 1'b1;
          step_up = 1'b1;
        end
        w.now = clock_now;
        send_word(w, 1'b0, '0);
        sent++;
      end
    end
    quiet = 1'b0;

    // drain and report
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_actions.size() != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("sfc_action_qualifier_top test passed");
    end else begin
      $display("sfc_action_qualifier_top test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("sfc_action_qualifier_top test failed");
    $finish;
  end

endmodule
